// ===== src/mbs_pkg.sv =====
// Shared types, codes and constants of the multipart boundary splitter.
package mbs_pkg;

    localparam int MAX_BOUNDARY = 32;
    localparam int BND_CAP      = (MAX_BOUNDARY < 32) ? MAX_BOUNDARY : 32;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;

    typedef enum logic [2:0] {
        K_CONTENT = 3'd0,
        K_PART    = 3'd1,
        K_FINAL   = 3'd2,
        K_UNTERM  = 3'd3,
        K_NOBOUND = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        PH_PRE_LINE = 3'd0,
        PH_PRE_SKIP = 3'd1,
        PH_PRE_TAIL = 3'd2,
        PH_BODY     = 3'd3,
        PH_POST     = 3'd4,
        PH_POST_CR  = 3'd5,
        PH_DONE     = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_RELEASE = 2'd1,
        S_TAIL    = 2'd2
    } t_seq;

    typedef enum logic [2:0] {
        CFG_LEN = 3'd0,
        CFG_W0  = 3'd1,
        CFG_W1  = 3'd2,
        CFG_W2  = 3'd3,
        CFG_W3  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       last_of_run;
    } t_out_item;

    typedef logic [3:0][63:0] t_bnd_words;

endpackage

// ===== src/mbs_pattern.sv =====
// Shared delimiter pattern unit: gives byte k of LF, two dashes, boundary.
module mbs_pattern
    import mbs_pkg::*;
(
    input  t_bnd_words i_words,
    input  logic [5:0] i_idx,
    output logic [7:0] o_byte
);

    logic [5:0] w_off;
    logic [4:0] w_sel;

    assign w_off = i_idx - 6'd3;
    assign w_sel = w_off[4:0];

    always_comb begin
        if (i_idx == 6'd0) begin
            o_byte = CH_LF;
        end else if (i_idx < 6'd3) begin
            o_byte = CH_DASH;
        end else begin
            o_byte = i_words[w_sel[4:3]][{w_sel[2:0], 3'b000} +: 8];
        end
    end

endmodule

// ===== src/mbs_core.sv =====
// Scanner state machine, release sequencer and output register.
module mbs_core
    import mbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic [5:0] i_blen,
    output logic [5:0] o_pat_idx,
    input  logic [7:0] i_pat_byte
);

    t_seq       r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [5:0] r_mp, n_mp;
    logic       r_cr, n_cr;
    logic       r_rel_cr, n_rel_cr;
    logic [5:0] r_rel_mp, n_rel_mp;
    logic [5:0] r_rel_k, n_rel_k;
    logic       r_tail, n_tail;
    logic [7:0] r_tail_byte, n_tail_byte;
    t_kind      r_tail_kind, n_tail_kind;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       w_out_free;
    logic       w_accept;
    logic       w_hit;
    logic [7:0] w_b;
    logic [6:0] w_mp_inc;
    logic       w_need_rel;
    logic       w_fresh;
    logic       w_emit;
    t_out_item  w_emit_data;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_b        = i_in_data.in_byte;
    assign w_hit      = (w_b == i_pat_byte);
    assign w_mp_inc   = {1'b0, r_mp} + 7'd1;

    // In the preamble the pattern is the body pattern without its leading LF.
    always_comb begin
        if (r_state == S_RELEASE) begin
            o_pat_idx = r_rel_k;
        end else if (r_phase == PH_BODY) begin
            o_pat_idx = r_mp;
        end else begin
            o_pat_idx = r_mp + 6'd1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_mp        = r_mp;
        n_cr        = r_cr;
        n_rel_cr    = r_rel_cr;
        n_rel_mp    = r_rel_mp;
        n_rel_k     = r_rel_k;
        n_tail      = r_tail;
        n_tail_byte = r_tail_byte;
        n_tail_kind = r_tail_kind;
        w_need_rel  = 1'b0;
        w_fresh     = 1'b0;
        w_emit      = 1'b0;
        w_emit_data = '{out_byte: 8'd0, kind: K_CONTENT, last_of_run: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_tail = 1'b0;
                    if (i_in_data.end_of_input) begin
                        case (r_phase)
                            PH_BODY: begin
                                if ((r_mp != 6'd0) || r_cr) begin
                                    w_need_rel  = 1'b1;
                                    n_tail      = 1'b1;
                                    n_tail_byte = 8'd0;
                                    n_tail_kind = K_UNTERM;
                                end else begin
                                    w_emit           = 1'b1;
                                    w_emit_data.kind = K_UNTERM;
                                end
                            end
                            PH_POST, PH_POST_CR: begin
                                w_emit           = 1'b1;
                                w_emit_data.kind = K_FINAL;
                            end
                            PH_DONE: begin
                            end
                            default: begin
                                w_emit           = 1'b1;
                                w_emit_data.kind = K_NOBOUND;
                            end
                        endcase
                        n_phase = PH_PRE_LINE;
                        n_mp    = 6'd0;
                        n_cr    = 1'b0;
                    end else begin
                        case (r_phase)
                            PH_PRE_SKIP: begin
                                if (w_b == CH_LF) begin
                                    n_phase = PH_PRE_LINE;
                                    n_mp    = 6'd0;
                                end
                            end
                            PH_PRE_TAIL: begin
                                if (w_b == CH_LF) begin
                                    n_phase = PH_BODY;
                                    n_mp    = 6'd0;
                                    n_cr    = 1'b0;
                                end
                            end
                            PH_BODY: begin
                                if ((r_mp == 6'd0) && !r_cr) begin
                                    w_fresh = 1'b1;
                                end else if (r_mp == 6'd0) begin
                                    if (w_b == CH_LF) begin
                                        n_mp = 6'd1;
                                    end else begin
                                        w_need_rel = 1'b1;
                                        w_fresh    = 1'b1;
                                    end
                                end else if (w_hit) begin
                                    n_mp = w_mp_inc[5:0];
                                    if (w_mp_inc >= ({1'b0, i_blen} + 7'd3)) begin
                                        n_phase = PH_POST;
                                        n_mp    = 6'd0;
                                        n_cr    = 1'b0;
                                    end
                                end else begin
                                    w_need_rel = 1'b1;
                                    w_fresh    = 1'b1;
                                end
                                if (w_fresh) begin
                                    if (w_need_rel) begin
                                        n_cr = 1'b0;
                                        n_mp = 6'd0;
                                    end
                                    if (w_b == CH_CR) begin
                                        n_cr = 1'b1;
                                    end else if (w_b == CH_LF) begin
                                        n_mp = 6'd1;
                                    end else if (w_need_rel) begin
                                        n_tail      = 1'b1;
                                        n_tail_byte = w_b;
                                        n_tail_kind = K_CONTENT;
                                    end else begin
                                        w_emit               = 1'b1;
                                        w_emit_data.out_byte = w_b;
                                    end
                                end
                            end
                            PH_POST, PH_POST_CR: begin
                                if (w_b == CH_LF) begin
                                    w_emit           = 1'b1;
                                    w_emit_data.kind = K_PART;
                                    n_phase          = PH_BODY;
                                end else if ((w_b == CH_CR) && (r_phase == PH_POST)) begin
                                    n_phase = PH_POST_CR;
                                end else begin
                                    w_emit           = 1'b1;
                                    w_emit_data.kind = K_FINAL;
                                    n_phase          = PH_DONE;
                                end
                            end
                            PH_DONE: begin
                            end
                            default: begin
                                if (w_hit) begin
                                    n_phase = PH_PRE_LINE;
                                    n_mp    = w_mp_inc[5:0];
                                    if (w_mp_inc >= ({1'b0, i_blen} + 7'd2)) begin
                                        n_phase = PH_PRE_TAIL;
                                        n_mp    = 6'd0;
                                    end
                                end else begin
                                    n_mp    = 6'd0;
                                    n_phase = (w_b == CH_LF) ? PH_PRE_LINE : PH_PRE_SKIP;
                                end
                            end
                        endcase
                    end
                    if (w_need_rel) begin
                        n_rel_cr = r_cr;
                        n_rel_mp = r_mp;
                        n_rel_k  = 6'd0;
                        n_state  = S_RELEASE;
                    end
                end
            end
            S_RELEASE: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_rel_cr) begin
                        w_emit_data.out_byte    = CH_CR;
                        w_emit_data.last_of_run = (r_rel_mp == 6'd0) && !r_tail;
                        n_rel_cr                = 1'b0;
                        if (r_rel_mp == 6'd0) begin
                            n_state = r_tail ? S_TAIL : S_IDLE;
                        end
                    end else begin
                        w_emit_data.out_byte    = i_pat_byte;
                        w_emit_data.last_of_run = ((r_rel_k + 6'd1) == r_rel_mp) && !r_tail;
                        n_rel_k                 = r_rel_k + 6'd1;
                        if ((r_rel_k + 6'd1) == r_rel_mp) begin
                            n_state = r_tail ? S_TAIL : S_IDLE;
                        end
                    end
                end
            end
            S_TAIL: begin
                if (w_out_free) begin
                    w_emit               = 1'b1;
                    w_emit_data.out_byte = r_tail_byte;
                    w_emit_data.kind     = r_tail_kind;
                    n_tail               = 1'b0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_PRE_LINE;
            r_mp        <= 6'd0;
            r_cr        <= 1'b0;
            r_rel_cr    <= 1'b0;
            r_rel_mp    <= 6'd0;
            r_rel_k     <= 6'd0;
            r_tail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_mp     <= n_mp;
            r_cr     <= n_cr;
            r_rel_cr <= n_rel_cr;
            r_rel_mp <= n_rel_mp;
            r_rel_k  <= n_rel_k;
            r_tail   <= n_tail;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail_byte <= n_tail_byte;
        r_tail_kind <= n_tail_kind;
        if (w_emit) begin
            r_out <= w_emit_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A release always has at least one held byte left to send.
    a_release_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELEASE) |-> (r_rel_cr || (r_rel_k < r_rel_mp)))
        else $error("release sequencer has nothing left to send");

    a_tail_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL) |-> r_tail)
        else $error("tail state without a pending tail result");

    a_cr_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cr |-> (r_phase == PH_BODY))
        else $error("held CR outside the body phase");

    a_release_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELEASE) && w_out_free |=>
            r_out_valid && (r_out.kind == K_CONTENT))
        else $error("released held byte is not a content result");

    a_new_request_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_in_data.end_of_input && (r_phase == PH_DONE) |=>
            !r_out_valid || $stable(r_out))
        else $error("epilogue byte produced a result");

endmodule

// ===== src/multipart_boundary_splitter_top.sv =====
// Top level of the MIME multipart boundary splitter: config registers and core.
// A byte that needs no release gives at most one result, shown in the output
// register on the next cycle; one byte per cycle is sustained while the output is
// ready and no release runs. A mismatch against held delimiter bytes sends them,
// then any trailing result, paced by a release sequencer sharing the pattern unit.
// Synchronous active-low reset: preamble at line start, nothing held, length 1.
module multipart_boundary_splitter_top
    import mbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // Raw boundary length as written, and the four words of boundary bytes.
    logic [5:0] r_len_raw;
    t_bnd_words r_words;

    // Effective length: zero counts as one, and anything above the cap saturates.
    logic [5:0] w_blen;
    logic [5:0] w_pat_idx;
    logic [7:0] w_pat_byte;

    // Configuration writes are always taken, unguarded; issue them only while idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_raw <= 6'd1;
            r_words   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LEN: r_len_raw  <= i_cfg_data[5:0];
                CFG_W0:  r_words[0] <= i_cfg_data;
                CFG_W1:  r_words[1] <= i_cfg_data;
                CFG_W2:  r_words[2] <= i_cfg_data;
                CFG_W3:  r_words[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_len_raw == 6'd0) begin
            w_blen = 6'd1;
        end else if (r_len_raw > 6'(BND_CAP)) begin
            w_blen = 6'(BND_CAP);
        end else begin
            w_blen = r_len_raw;
        end
    end

    // The pattern unit serves both the match compare and the release of held bytes.
    mbs_pattern u_pattern (
        .i_words (r_words),
        .i_idx   (w_pat_idx),
        .o_byte  (w_pat_byte)
    );

    mbs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_blen      (w_blen),
        .o_pat_idx   (w_pat_idx),
        .i_pat_byte  (w_pat_byte)
    );

endmodule
